@@ sv/bci_pkg.sv @@
// Package for the breakpoint curve interpolator: constants, opcodes, status codes.
// No dependencies.
`timescale 1ns / 1ps
package bci_pkg;
    localparam int MAX_POINTS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 15;
    localparam int VAL_W          = 16;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_DEL   = 2'd1,
        OP_EVAL  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_FULL     = 2'd1,
        ST_NOTFOUND = 2'd2
    } status_t;

    localparam logic [1:0] REG_ACTIVE = 2'd0;
    localparam logic [1:0] REG_LOW    = 2'd1;
    localparam logic [1:0] REG_HIGH   = 2'd2;
endpackage

@@ sv/breakpoint_curve_interpolator_top.sv @@
// Breakpoint curve interpolator top level: point memory, sequencer, APB registers.
// Depends on bci_pkg and bci_div.
//
// channel | direction | handshake       | payload
// in      | input     | valid / ready   | opcode, position, point_level, point_wrapped
// out     | output    | out_valid/ready | curve_level, scaled_level, status, points_held
// apb     | input     | psel / penable  | curve_active, low_bound, high_bound
//
// One word at a time. Each item but a clear scans the point memory one entry a cycle;
// insert and delete then shift entries one at a time, read in S_SHRD and written back
// in S_SHWR; evaluate may add the bit-serial divide in bci_div. Reset leaves the table empty.
// A held result stalls the next item until it is taken.
`timescale 1ns / 1ps
module breakpoint_curve_interpolator_top
    import bci_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
)(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  logic [1:0]        opcode,
    input  logic [15:0]       position,
    input  logic [15:0]       point_level,
    input  logic              point_wrapped,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [15:0]       curve_level,
    output logic signed [15:0] scaled_level,
    output logic [1:0]        status,
    output logic [5:0]        points_held,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW_CNT = $clog2(MAX_POINTS + 1);
    localparam logic [16:0] ONE_Q = 17'(1) << FRAC_BITS;
    localparam int EW = 33;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_SCAN  = 9'b000000010,
        S_DEC   = 9'b000000100,
        S_SHRD  = 9'b000001000,
        S_SHWR  = 9'b000010000,
        S_EVRD  = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_SCALE = 9'b010000000,
        S_OUT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [32:0] mem [MAX_POINTS];
    logic [32:0] rd_data;
    logic        we;
    logic [AW-1:0] waddr, raddr;
    logic [32:0] wdata;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data <= mem[raddr];
    end

    logic              active_reg;
    logic signed [15:0] low_reg, high_reg;
    logic [NW_CNT-1:0] total_reg, total_next;

    logic [1:0]  op_reg;
    logic [15:0] pos_reg, lvl_reg;
    logic        wrap_reg;

    logic [NW_CNT-1:0] k_reg, k_next;
    logic              rv_reg, rv_next;
    logic [NW_CNT-1:0] ridx_reg, ridx_next;
    logic [32:0]       prev_reg, prev_next;
    logic              hit_reg, hit_next;
    logic [NW_CNT-1:0] sh_reg, sh_next;
    logic [16:0]       res_reg, res_next;
    logic [1:0]        st_reg, st_next;
    logic              ov_reg;
    logic              div_start;
    logic              div_done;
    logic signed [EW-1:0] div_num, div_q;
    logic [16:0]       div_den;
    logic signed [17:0] ly_reg;
    logic signed [34:0] prod;
    logic signed [35:0] sc_wide;
    logic [16:0]       p_sat, y_sat;

    assign pready = 1'b1;
    assign p_sat = ({1'b0, position} > ONE_Q) ? ONE_Q : {1'b0, position};
    assign y_sat = ({1'b0, point_level} > ONE_Q) ? ONE_Q : {1'b0, point_level};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            low_reg    <= '0;
            high_reg   <= 16'sd100;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_ACTIVE: active_reg <= pwdata[0];
                REG_LOW:    low_reg    <= pwdata[15:0];
                REG_HIGH:   high_reg   <= pwdata[15:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_ACTIVE: prdata = {31'd0, active_reg};
            REG_LOW:    prdata = {{16{low_reg[15]}}, low_reg};
            REG_HIGH:   prdata = {{16{high_reg[15]}}, high_reg};
            default:    prdata = '0;
        endcase
    end

    assign ready = (state_reg == S_IDLE) && !ov_reg;

    logic [15:0] rx;
    assign rx = rd_data[32:17];

    always_comb
    begin
        state_next = state_reg;
        total_next = total_reg;
        k_next     = k_reg;
        rv_next    = 1'b0;
        ridx_next  = ridx_reg;
        prev_next  = prev_reg;
        hit_next   = hit_reg;
        sh_next    = sh_reg;
        res_next   = res_reg;
        st_next    = st_reg;
        we         = 1'b0;
        waddr      = k_reg[AW-1:0];
        wdata      = {pos_reg, lvl_reg, wrap_reg};
        raddr      = ridx_reg[AW-1:0];
        div_start  = 1'b0;
        div_num    = '0;
        div_den    = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (valid && ready)
                begin
                    k_next    = '0;
                    ridx_next = '0;
                    hit_next  = 1'b0;
                    st_next   = ST_DONE;
                    res_next  = '0;
                    if (opcode == OP_CLEAR)
                    begin
                        total_next = '0;
                        state_next = S_OUT;
                    end
                    else if (total_reg == '0)
                    begin
                        state_next = S_DEC;
                    end
                    else
                    begin
                        raddr     = '0;
                        rv_next   = 1'b1;
                        ridx_next = NW_CNT'(1);
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (rv_reg)
                begin
                    if (rx < pos_reg)
                    begin
                        k_next = k_reg + 1'b1;
                        if (k_reg + 1'b1 == total_reg)
                        begin
                            state_next = S_DEC;
                        end
                        else
                        begin
                            raddr     = ridx_reg[AW-1:0];
                            rv_next   = 1'b1;
                            ridx_next = ridx_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        hit_next   = (rx == pos_reg);
                        state_next = S_DEC;
                    end
                end
            end
            S_DEC:
            begin
                case (op_reg)
                    OP_SET:
                    begin
                        if (hit_reg)
                        begin
                            we = 1'b1;
                            state_next = S_OUT;
                        end
                        else if (total_reg >= NW_CNT'(MAX_POINTS))
                        begin
                            st_next = ST_FULL;
                            state_next = S_OUT;
                        end
                        else
                        begin
                            sh_next = total_reg;
                            state_next = S_SHRD;
                        end
                    end
                    OP_DEL:
                    begin
                        if (hit_reg && total_reg > NW_CNT'(2))
                        begin
                            sh_next = k_reg;
                            state_next = S_SHRD;
                        end
                        else
                        begin
                            st_next = ST_NOTFOUND;
                            state_next = S_OUT;
                        end
                    end
                    default:
                    begin
                        if (!active_reg || total_reg < NW_CNT'(2))
                        begin
                            res_next = ONE_Q;
                            state_next = S_SCALE;
                        end
                        else
                        begin
                            if (k_reg == '0)
                            begin
                                k_next = NW_CNT'(1);
                            end
                            ridx_next = '0;
                            state_next = S_EVRD;
                        end
                    end
                endcase
            end
            S_SHRD:
            begin
                if (op_reg == OP_SET)
                begin
                    if (sh_reg == k_reg)
                    begin
                        we = 1'b1;
                        total_next = total_reg + 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        raddr = AW'(sh_reg - 1'b1);
                        state_next = S_SHWR;
                    end
                end
                else
                begin
                    if (sh_reg + 1'b1 == total_reg)
                    begin
                        total_next = total_reg - 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        raddr = AW'(sh_reg + 1'b1);
                        state_next = S_SHWR;
                    end
                end
            end
            S_SHWR:
            begin
                we    = 1'b1;
                waddr = sh_reg[AW-1:0];
                wdata = rd_data;
                sh_next = (op_reg == OP_SET) ? sh_reg - 1'b1 : sh_reg + 1'b1;
                state_next = S_SHRD;
            end
            S_EVRD:
            begin
                // ridx: 0 issue prev, 1 prev back and issue cur, 2 cur back
                ridx_next = ridx_reg + 1'b1;
                if (ridx_reg == NW_CNT'(0))
                begin
                    if (k_reg == total_reg)
                    begin
                        raddr = AW'(total_reg - 1'b1);
                    end
                    else
                    begin
                        raddr = AW'(k_reg - 1'b1);
                    end
                end
                else if (ridx_reg == NW_CNT'(1))
                begin
                    raddr = k_reg[AW-1:0];
                    prev_next = rd_data;
                end
                else
                begin
                    if (k_reg == total_reg)
                    begin
                        res_next = {1'b0, prev_reg[16:1]};
                        state_next = S_SCALE;
                    end
                    else if (rd_data[32:17] == prev_reg[32:17] ||
                             rd_data[32:17] == pos_reg || rd_data[0])
                    begin
                        res_next = {1'b0, rd_data[16:1]};
                        state_next = S_SCALE;
                    end
                    else
                    begin
                        div_start = 1'b1;
                        div_num = EW'((18'sd0 + $signed({2'b0, rd_data[16:1]})
                                      - $signed({2'b0, prev_reg[16:1]}))
                                      * ($signed({2'b0, pos_reg})
                                      - $signed({2'b0, prev_reg[32:17]})));
                        div_den = {1'b0, rd_data[32:17] - prev_reg[32:17]};
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if ($signed(div_q) + $signed({1'b0, prev_reg[16:1]}) < 0)
                    begin
                        res_next = '0;
                    end
                    else if ($signed(div_q) + $signed({1'b0, prev_reg[16:1]})
                             > $signed({1'b0, ONE_Q}))
                    begin
                        res_next = ONE_Q;
                    end
                    else
                    begin
                        res_next = 17'(div_q + EW'(prev_reg[16:1]));
                    end
                    state_next = S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (state_reg == S_SCAN && !rv_reg)
        begin
            state_next = S_DEC;
        end
    end

    bci_div #(.NW(EW), .DW(17)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_q)
    );

    assign sc_wide = 36'(prod >>> FRAC_BITS) + 36'(low_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            total_reg <= '0;
            ov_reg    <= 1'b0;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            total_reg <= total_next;
            rv_reg    <= rv_next;
            if (state_reg == S_OUT)
            begin
                ov_reg <= 1'b1;
            end
            else if (ov_reg && out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg    <= k_next;
        ridx_reg <= ridx_next;
        prev_reg <= prev_next;
        hit_reg  <= hit_next;
        sh_reg   <= sh_next;
        res_reg  <= res_next;
        st_reg   <= st_next;
        ly_reg   <= 18'(high_reg) - 18'(low_reg);
        if (valid && ready)
        begin
            op_reg   <= opcode;
            pos_reg  <= p_sat[15:0];
            lvl_reg  <= y_sat[15:0];
            wrap_reg <= point_wrapped;
        end
        if (state_reg == S_SCALE)
        begin
            prod <= ly_reg * $signed({1'b0, res_reg});
        end
        if (state_reg == S_OUT)
        begin
            curve_level <= (op_reg == OP_EVAL) ? res_reg[15:0] : '0;
            status      <= st_reg;
            points_held <= 6'(total_reg);
            if (op_reg != OP_EVAL)
            begin
                scaled_level <= '0;
            end
            else if (sc_wide > 36'sd32767)
            begin
                scaled_level <= 16'sh7fff;
            end
            else if (sc_wide < -36'sd32768)
            begin
                scaled_level <= 16'sh8000;
            end
            else
            begin
                scaled_level <= sc_wide[15:0];
            end
        end
    end

    assign out_valid = ov_reg;
endmodule

@@ sv/bci_div.sv @@
// Restoring divider, one quotient bit per cycle, truncates toward zero.
// Depends on bci_pkg.
`timescale 1ns / 1ps
module bci_div
    import bci_pkg::*;
#(
    parameter int NW = 33,
    parameter int DW = 17
)(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [NW-1:0] num,
    input  logic        [DW-1:0] den,
    output logic                 done,
    output logic signed [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW:0]   r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic          neg_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {r_reg[DW-1:0], q_reg[NW-1]};
        if (busy_reg)
        begin
            q_next = {q_reg[NW-2:0], 1'b0};
            if (trial >= {1'b0, d_reg})
            begin
                r_next    = trial - {1'b0, d_reg};
                q_next[0] = 1'b1;
            end
            else
            begin
                r_next = trial;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done     <= 1'b0;
        end
        else
        begin
            done <= busy_reg && (cnt_reg == CW'(1));
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else
            begin
                busy_reg <= busy_next;
                cnt_reg  <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= num[NW-1] ? NW'(-num) : num;
            neg_reg <= num[NW-1];
            d_reg   <= den;
            r_reg   <= '0;
        end
        else
        begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quo = neg_reg ? -$signed(q_reg) : $signed(q_reg);
endmodule

@@ sv/bci_checker.sv @@
// Port-level checker for the breakpoint curve interpolator, bound to the top level.
// Depends on bci_pkg.
`timescale 1ns / 1ps
module bci_props
    import bci_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        valid,
    input logic        ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  opcode,
    input logic [15:0] curve_level,
    input logic [1:0]  status
);
    a_no_accept_while_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !ready) else $error("accepted while word held");
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(curve_level))
        else $error("word changed under stall");
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> curve_level <= 16'd32768) else $error("level out of range");
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status != 2'd3) else $error("bad status");
    a_clear_empty: assert property (@(posedge clk) disable iff (!rst_n)
        valid && ready && opcode == OP_CLEAR |=> !out_valid) else $error("early word");
endmodule

bind breakpoint_curve_interpolator_top bci_props u_chk (
    .clk(clk), .rst_n(rst_n), .valid(valid), .ready(ready),
    .out_valid(out_valid), .out_ready(out_ready), .opcode(opcode),
    .curve_level(curve_level), .status(status)
);

@@ sim/bci_checker.sv @@
// Checker for the breakpoint curve interpolator: watches the in and out channels and the
// register port, predicts each result word and compares it. Depends on bci_pkg.
`timescale 1ns / 1ps
module bci_checker
    import bci_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    input  logic              ready,
    input  logic [1:0]        opcode,
    input  logic [15:0]       position,
    input  logic [15:0]       point_level,
    input  logic              point_wrapped,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [15:0]       curve_level,
    input  logic signed [15:0] scaled_level,
    input  logic [1:0]        status,
    input  logic [5:0]        points_held,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);
    localparam int ONE = 32768;

    typedef struct packed {
        logic [15:0] level;
        logic [15:0] scaled;
        status_t     st;
        logic [5:0]  held;
    } curve_word_t;

    curve_word_t expected_words[$];

    int unsigned bp_x[MAX_POINTS_DEF];
    int unsigned bp_y[MAX_POINTS_DEF];
    bit          bp_wrap[MAX_POINTS_DEF];
    int          bp_count;
    bit          active_q;
    longint      low_q;
    longint      high_q;

    function automatic int unsigned clamp_one(logic [15:0] v);
        return (v > ONE) ? ONE : int'(v);
    endfunction

    function automatic longint curve_at(int unsigned q);
        int     prev;
        int     nxt;
        longint r;
        longint dy;
        longint dx;
        longint d;
        prev = 0;
        nxt = 1;
        if (!active_q || bp_count < 2)
            return ONE;
        while (nxt < bp_count && bp_x[nxt] < q)
        begin
            prev = nxt;
            nxt++;
        end
        if (nxt >= bp_count)
            r = bp_y[bp_count-1];
        else if (bp_x[nxt] == bp_x[prev] || bp_x[nxt] == q || bp_wrap[nxt])
            r = bp_y[nxt];
        else
        begin
            dy = longint'(bp_y[nxt]) - longint'(bp_y[prev]);
            dx = longint'(bp_x[nxt]) - longint'(bp_x[prev]);
            d = longint'(q) - longint'(bp_x[prev]);
            r = longint'(bp_y[prev]) + (dy * d) / dx;
        end
        if (r < 0) r = 0;
        if (r > ONE) r = ONE;
        return r;
    endfunction

    function automatic curve_word_t apply_item(op_t op, logic [15:0] p, logic [15:0] lv,
                                               logic w);
        curve_word_t res;
        int unsigned q;
        int          k;
        longint      lvl;
        longint      prod;
        longint      sc;
        q = clamp_one(p);
        k = 0;
        res = '0;
        res.st = ST_DONE;
        while (k < bp_count && bp_x[k] < q) k++;
        case (op)
            OP_SET:
            begin
                if (k < bp_count && bp_x[k] == q)
                begin
                    bp_y[k] = clamp_one(lv);
                    bp_wrap[k] = w;
                end
                else if (bp_count >= MAX_POINTS_DEF)
                    res.st = ST_FULL;
                else
                begin
                    for (int j = bp_count; j > k; j--)
                    begin
                        bp_x[j] = bp_x[j-1];
                        bp_y[j] = bp_y[j-1];
                        bp_wrap[j] = bp_wrap[j-1];
                    end
                    bp_x[k] = q;
                    bp_y[k] = clamp_one(lv);
                    bp_wrap[k] = w;
                    bp_count++;
                end
            end
            OP_DEL:
            begin
                if (bp_count > 2 && k < bp_count && bp_x[k] == q)
                begin
                    for (int j = k; j < bp_count - 1; j++)
                    begin
                        bp_x[j] = bp_x[j+1];
                        bp_y[j] = bp_y[j+1];
                        bp_wrap[j] = bp_wrap[j+1];
                    end
                    bp_count--;
                end
                else
                    res.st = ST_NOTFOUND;
            end
            OP_EVAL:
            begin
                lvl = curve_at(q);
                prod = (high_q - low_q) * lvl;
                if (prod >= 0)
                    sc = low_q + (prod >>> 15);
                else
                    sc = low_q - (((-prod) + ONE - 1) >>> 15);
                if (sc < -32768) sc = -32768;
                if (sc > 32767) sc = 32767;
                res.level = lvl[15:0];
                res.scaled = sc[15:0];
            end
            OP_CLEAR: bp_count = 0;
            default: ;
        endcase
        res.held = bp_count[5:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        curve_word_t exp_w;
        if (!rst_n)
        begin
            expected_words.delete();
            bp_count = 0;
            active_q = 0;
            low_q = 0;
            high_q = 100;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_ACTIVE: active_q = pwdata[0];
                    REG_LOW:    low_q = longint'($signed(pwdata[15:0]));
                    REG_HIGH:   high_q = longint'($signed(pwdata[15:0]));
                    default: ;
                endcase
            end
            if (valid && ready)
                expected_words = {expected_words, apply_item(op_t'(opcode), position,
                                                             point_level, point_wrapped)};
            if (out_valid && out_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected result word");
                    fail_count++;
                end
                else
                begin
                    exp_w = expected_words.pop_front();
                    if (curve_level !== exp_w.level)
                    begin
                        $error("curve_level exp %0d got %0d", exp_w.level, curve_level);
                        fail_count++;
                    end
                    if (scaled_level !== exp_w.scaled)
                    begin
                        $error("scaled_level exp %0d got %0d", $signed(exp_w.scaled),
                               scaled_level);
                        fail_count++;
                    end
                    if (status !== exp_w.st)
                    begin
                        $error("status exp %0d got %0d", exp_w.st, status);
                        fail_count++;
                    end
                    if (points_held !== exp_w.held)
                    begin
                        $error("points_held exp %0d got %0d", exp_w.held, points_held);
                        fail_count++;
                    end
                end
            end
            pending = expected_words.size();
        end
    end
endmodule

@@ sim/testbench.sv @@
// Testbench top for the breakpoint curve interpolator: clock, reset, stimulus, verdict.
// Depends on bci_pkg, breakpoint_curve_interpolator_top and bci_checker.
`timescale 1ns / 1ps
module testbench;
    import bci_pkg::*;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        valid = 0;
    logic        ready;
    logic [1:0]  opcode = OP_SET;
    logic [15:0] position = 0;
    logic [15:0] point_level = 0;
    logic        point_wrapped = 0;
    logic        out_valid;
    logic        out_ready = 0;
    logic [15:0] curve_level;
    logic signed [15:0] scaled_level;
    logic [1:0]  status;
    logic [5:0]  points_held;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [3:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    bit          calm = 0;
    bit          stim_done = 0;

    always #5 clk = ~clk;

    breakpoint_curve_interpolator_top u_dut (.*);
    bci_checker u_chk (.*);

    initial
    begin
        #50ms;
        $display("simulation failed");
        $finish;
    end

    always @(negedge clk)
        out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);

    task automatic reg_write(logic [1:0] idx, logic [31:0] val);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        valid <= 0;
        while (pending != 0) @(negedge clk);
        repeat (80) @(negedge clk);
    endtask

    task automatic send_word(op_t op, logic [15:0] p, logic [15:0] lv, logic w);
        if (!calm && $urandom_range(99) < 11)
        begin
            valid <= 0;
            @(negedge clk);
            while ($urandom_range(99) < 11) @(negedge clk);
        end
        valid <= 1; opcode <= op; position <= p; point_level <= lv; point_wrapped <= w;
        do @(posedge clk); while (!ready);
        @(negedge clk);
    endtask

    task automatic random_phase(int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            calm = (i >= count / 3 && i < count / 3 + 60);
            if (r < 40)
                send_word(OP_SET, (r < 5) ? 16'($urandom) : 16'($urandom_range(32768)),
                          (r < 8) ? 16'($urandom) : 16'($urandom_range(32768)),
                          $urandom_range(3) == 0);
            else if (r < 52)
                send_word(OP_DEL, 16'($urandom_range(32768)), 16'($urandom), 1'($urandom));
            else if (r < 97)
                send_word(OP_EVAL, (r < 60) ? 16'($urandom) : 16'($urandom_range(32768)),
                          16'($urandom), 1'($urandom));
            else
                send_word(OP_CLEAR, 16'($urandom), 16'($urandom), 1'($urandom));
        end
        calm = 0;
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1;
        repeat (2) @(negedge clk);
        send_word(OP_EVAL, 16'h4000, 0, 0);
        drain();
        reg_write(REG_ACTIVE, 1);
        send_word(OP_SET, 16'hFFFF, 16'hFFFF, 1);
        send_word(OP_EVAL, 16'h1000, 0, 0);
        send_word(OP_SET, 16'h0000, 16'h0000, 0);
        send_word(OP_SET, 16'h4000, 16'h6000, 0);
        send_word(OP_SET, 16'h6000, 16'h2000, 1);
        send_word(OP_SET, 16'h4000, 16'h7000, 0);
        send_word(OP_EVAL, 16'h2000, 0, 0);
        send_word(OP_EVAL, 16'h4000, 0, 0);
        send_word(OP_EVAL, 16'h5000, 0, 0);
        send_word(OP_EVAL, 16'h7000, 0, 0);
        send_word(OP_EVAL, 16'h9000, 0, 0);
        send_word(OP_DEL, 16'h1234, 0, 0);
        send_word(OP_DEL, 16'h6000, 0, 0);
        send_word(OP_DEL, 16'h4000, 0, 0);
        send_word(OP_SET, 16'h0100, 16'h8000, 0);
        send_word(OP_SET, 16'h0200, 16'h0000, 0);
        send_word(OP_EVAL, 16'h0000, 0, 0);
        for (int i = 0; i < 33; i++)
            send_word(OP_SET, 16'(i * 900 + 7), 16'($urandom_range(32768)), 0);
        send_word(OP_SET, 16'h0100, 16'h1111, 1);
        send_word(OP_EVAL, 16'h3000, 0, 0);
        send_word(OP_CLEAR, 0, 0, 0);
        drain();
        reg_write(REG_LOW, 32'hFFFF_8000);
        reg_write(REG_HIGH, 32'h0000_7FFF);
        random_phase(380);
        drain();
        reg_write(REG_LOW, 32'h0000_7FFF);
        reg_write(REG_HIGH, 32'hFFFF_8000);
        random_phase(380);
        drain();
        reg_write(REG_ACTIVE, 0);
        reg_write(REG_LOW, 32'h0000_0123);
        reg_write(REG_HIGH, 32'hFFFF_FF00);
        random_phase(60);
        drain();
        reg_write(REG_ACTIVE, 1);
        random_phase(280);
        drain();
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

@@ sim.f @@
sv/bci_pkg.sv
sv/bci_div.sv
sv/breakpoint_curve_interpolator_top.sv
sv/bci_checker.sv
sim/bci_checker.sv
sim/testbench.sv
